// ===== rtl/core/fvdiv_pkg.sv =====
// ============================================================================
// fvdiv_pkg
// Shared types and constants of the finite-volume divergence core.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package fvdiv_pkg;

    localparam int MAX_CELLS  = 4096;
    localparam int CELL_AW    = $clog2(MAX_CELLS);
    localparam int FRAC_BITS  = 16;
    localparam int WEIGHT_ONE = 1 << FRAC_BITS;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_FACE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic CFG_CELL_COUNT = 1'b0;
    localparam logic CFG_FACE_MODE  = 1'b1;

    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RD_L,
        ST_RD_R,
        ST_CAP_R,
        ST_MUL,
        ST_ACC,
        ST_RD_A,
        ST_WR_A,
        ST_RD_B,
        ST_WR_B,
        ST_RD_S,
        ST_DIV_PRE,
        ST_DIV,
        ST_ROUND,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/fv_vector_divergence_core.sv =====
// ============================================================================
// fv_vector_divergence_core
// Gauss-theorem divergence of a cell vector field in Q16.16 fixed point.
// ============================================================================
// Each transfer is handled alone while s_tready is low. A load is written in ST_LOAD.
// A face that is interpolated takes two vector reads, six products for the face
// vector and three for the flux, each product and its accumulation going through
// the one shared multiplier in ST_MUL and ST_ACC; when the face vector comes with
// the transfer only the flux products remain. Both ways the left accumulator is
// updated, and the right one too when the right cell is interior. A read runs the
// 32 steps of the restoring divider, or skips them when the quotient clips, and the
// result then waits for m_tready. The memories hold unknown data after reset; the
// user must load cells before use, as the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module fv_vector_divergence_core
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // cell_index, right_cell, left_weight, value_x, value_y, value_z,
    // area_x, area_y, area_z, cell_volume, zero fill
    input  wire logic [271:0] s_tdata,
    // op
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result_cell, divergence, zero fill
    output logic [47:0]       m_tdata,
    // saturated
    output logic              m_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [12:0]  cfg_data
);

    localparam int AW = fvdiv_pkg::CELL_AW;
    localparam int FB = fvdiv_pkg::FRAC_BITS;

    fvdiv_pkg::state_t state_reg, state_next;

    logic [12:0] cell_count_reg;
    logic        face_mode_reg;

    logic [1:0]  op_reg;
    logic [AW-1:0] cl_reg;
    logic [12:0] cr_reg;
    logic [16:0] w_reg;
    logic signed [31:0] val_reg  [3];
    logic signed [31:0] area_reg [3];
    logic [30:0] vol_in_reg;

    logic signed [31:0] lvec_reg [3];
    logic signed [31:0] rvec_reg [3];
    logic signed [31:0] q_reg    [3];
    logic [3:0]  step_reg;
    logic signed [65:0] acc_reg;
    logic signed [65:0] prod_reg;
    logic signed [49:0] flux_reg;

    logic        neg_reg;
    logic [30:0] dvol_reg;
    logic [30:0] rem_reg;
    logic [31:0] quot_reg;
    logic [31:0] shift_reg;
    logic [4:0]  cnt_reg;

    logic        m_valid_reg;
    logic [AW-1:0] m_cell_reg;
    logic [31:0] m_div_reg;
    logic        m_sat_reg;
    logic [31:0] res_reg;
    logic        sat_reg;

    logic [95:0] vec_mem  [fvdiv_pkg::MAX_CELLS];
    logic [30:0] vol_mem  [fvdiv_pkg::MAX_CELLS];
    logic [63:0] flux_mem [fvdiv_pkg::MAX_CELLS];
    logic [95:0] vec_rd_data;
    logic [30:0] vol_rd_data;
    logic [63:0] flux_rd_data;

    logic          vec_re;
    logic [AW-1:0] vec_raddr;
    logic          flux_re;
    logic [AW-1:0] flux_raddr;
    logic          flux_we;
    logic [AW-1:0] flux_waddr;
    logic [63:0]   flux_wdata;
    logic          load_we;
    logic          vol_re;

    logic          accept;
    logic          out_load;
    logic [16:0]   w_clamp;
    logic [16:0]   wr;
    logic [1:0]    k_sel;
    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic signed [31:0] q_src;
    logic signed [65:0] acc_sum;
    logic signed [64:0] sat_sum;
    logic [12:0]   active;
    logic          right_interior;
    logic [31:0]   trial;
    logic [32:0]   q_round;
    logic [32:0]   limit;
    logic [31:0]   q_clip;
    logic          q_over;
    logic [64:0]   vol_shift;
    logic [63:0]   rd_mag;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == fvdiv_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {4'b0, m_div_reg, m_cell_reg};
    assign m_tuser   = m_sat_reg;
    assign out_load  = (state_reg == fvdiv_pkg::ST_OUT) && (!m_valid_reg || m_tready);

    assign w_clamp = (w_reg > 17'(fvdiv_pkg::WEIGHT_ONE)) ?
                     17'(fvdiv_pkg::WEIGHT_ONE) : w_reg;
    assign wr      = 17'(fvdiv_pkg::WEIGHT_ONE) - w_clamp;
    assign active  = (cell_count_reg > 13'(fvdiv_pkg::MAX_CELLS)) ?
                     13'(fvdiv_pkg::MAX_CELLS) : cell_count_reg;
    assign right_interior = cr_reg < active;

    always_comb
    begin
        case (step_reg)
            4'd0, 4'd1: k_sel = 2'd0;
            4'd2, 4'd3: k_sel = 2'd1;
            4'd4, 4'd5: k_sel = 2'd2;
            4'd6:       k_sel = 2'd0;
            4'd7:       k_sel = 2'd1;
            4'd8:       k_sel = 2'd2;
            default:    k_sel = 2'd0;
        endcase
    end

    always_comb
    begin
        q_src = face_mode_reg ? val_reg[k_sel] : q_reg[k_sel];
        if (step_reg >= 4'd6)
        begin
            op_a = 33'(q_src);
            op_b = 33'(area_reg[k_sel]);
        end
        else if (step_reg[0] == 1'b0)
        begin
            op_a = $signed({16'b0, w_clamp});
            op_b = 33'(lvec_reg[k_sel]);
        end
        else
        begin
            op_a = $signed({16'b0, wr});
            op_b = 33'(rvec_reg[k_sel]);
        end
    end

    assign acc_sum = acc_reg + prod_reg;

    assign rd_mag   = flux_rd_data[63] ? (64'b0 - flux_rd_data) : flux_rd_data;
    assign trial    = {rem_reg, shift_reg[31]} - {1'b0, dvol_reg};
    assign q_round  = {1'b0, quot_reg} + 33'({rem_reg, 1'b0} >= {1'b0, dvol_reg});
    assign limit    = neg_reg ? {1'b0, fvdiv_pkg::NEG_LIMIT} : {1'b0, fvdiv_pkg::POS_LIMIT};
    assign q_over   = q_round > limit;
    assign q_clip   = q_over ? limit[31:0] : q_round[31:0];
    assign vol_shift = {18'b0, vol_rd_data, 16'b0};

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            vec_mem[cl_reg] <= {val_reg[2], val_reg[1], val_reg[0]};
            vol_mem[cl_reg] <= vol_in_reg;
        end
        if (vec_re)
        begin
            vec_rd_data <= vec_mem[vec_raddr];
        end
        if (vol_re)
        begin
            vol_rd_data <= vol_mem[cl_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (flux_we)
        begin
            flux_mem[flux_waddr] <= flux_wdata;
        end
        if (flux_re)
        begin
            flux_rd_data <= flux_mem[flux_raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fvdiv_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        fvdiv_pkg::OP_LOAD: state_next = fvdiv_pkg::ST_LOAD;
                        fvdiv_pkg::OP_FACE: state_next = face_mode_reg ?
                                            fvdiv_pkg::ST_MUL : fvdiv_pkg::ST_RD_L;
                        fvdiv_pkg::OP_READ: state_next = fvdiv_pkg::ST_RD_S;
                        default:            state_next = fvdiv_pkg::ST_IDLE;
                    endcase
                end
            end
            fvdiv_pkg::ST_LOAD:    state_next = fvdiv_pkg::ST_IDLE;
            fvdiv_pkg::ST_RD_L:    state_next = fvdiv_pkg::ST_RD_R;
            fvdiv_pkg::ST_RD_R:    state_next = fvdiv_pkg::ST_CAP_R;
            fvdiv_pkg::ST_CAP_R:   state_next = fvdiv_pkg::ST_MUL;
            fvdiv_pkg::ST_MUL:     state_next = fvdiv_pkg::ST_ACC;
            fvdiv_pkg::ST_ACC:     state_next = (step_reg == 4'd8) ?
                                   fvdiv_pkg::ST_RD_A : fvdiv_pkg::ST_MUL;
            fvdiv_pkg::ST_RD_A:    state_next = fvdiv_pkg::ST_WR_A;
            fvdiv_pkg::ST_WR_A:    state_next = right_interior ?
                                   fvdiv_pkg::ST_RD_B : fvdiv_pkg::ST_IDLE;
            fvdiv_pkg::ST_RD_B:    state_next = fvdiv_pkg::ST_WR_B;
            fvdiv_pkg::ST_WR_B:    state_next = fvdiv_pkg::ST_IDLE;
            fvdiv_pkg::ST_RD_S:    state_next = fvdiv_pkg::ST_DIV_PRE;
            fvdiv_pkg::ST_DIV_PRE: state_next = ({1'b0, rd_mag} >= vol_shift) ?
                                   fvdiv_pkg::ST_OUT : fvdiv_pkg::ST_DIV;
            fvdiv_pkg::ST_DIV:     state_next = (cnt_reg == 5'd31) ?
                                   fvdiv_pkg::ST_ROUND : fvdiv_pkg::ST_DIV;
            fvdiv_pkg::ST_ROUND:   state_next = fvdiv_pkg::ST_OUT;
            fvdiv_pkg::ST_OUT:     state_next = out_load ?
                                   fvdiv_pkg::ST_IDLE : fvdiv_pkg::ST_OUT;
            default:               state_next = fvdiv_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        vec_re     = 1'b0;
        vec_raddr  = cl_reg;
        flux_re    = 1'b0;
        flux_raddr = cl_reg;
        flux_we    = 1'b0;
        flux_waddr = cl_reg;
        flux_wdata = 64'b0;
        load_we    = 1'b0;
        vol_re     = 1'b0;
        sat_sum    = 65'sb0;
        case (state_reg)
            fvdiv_pkg::ST_LOAD:
            begin
                load_we = 1'b1;
                flux_we = 1'b1;
            end
            fvdiv_pkg::ST_RD_L:
            begin
                vec_re = 1'b1;
            end
            fvdiv_pkg::ST_RD_R:
            begin
                vec_re    = 1'b1;
                vec_raddr = cr_reg[AW-1:0];
            end
            fvdiv_pkg::ST_RD_A:
            begin
                flux_re = 1'b1;
            end
            fvdiv_pkg::ST_WR_A:
            begin
                sat_sum = 65'($signed(flux_rd_data)) - 65'(flux_reg);
                flux_we = 1'b1;
            end
            fvdiv_pkg::ST_RD_B:
            begin
                flux_re    = 1'b1;
                flux_raddr = cr_reg[AW-1:0];
            end
            fvdiv_pkg::ST_WR_B:
            begin
                sat_sum    = 65'($signed(flux_rd_data)) + 65'(flux_reg);
                flux_we    = 1'b1;
                flux_waddr = cr_reg[AW-1:0];
            end
            fvdiv_pkg::ST_RD_S:
            begin
                flux_re = 1'b1;
                vol_re  = 1'b1;
            end
            default:
            begin
                flux_we = 1'b0;
            end
        endcase
        if (state_reg == fvdiv_pkg::ST_WR_A || state_reg == fvdiv_pkg::ST_WR_B)
        begin
            if (sat_sum[64] != sat_sum[63])
            begin
                flux_wdata = sat_sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
            end
            else
            begin
                flux_wdata = sat_sum[63:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fvdiv_pkg::ST_IDLE;
            cell_count_reg <= 13'(fvdiv_pkg::MAX_CELLS);
            face_mode_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fvdiv_pkg::CFG_CELL_COUNT: cell_count_reg <= cfg_data;
                    fvdiv_pkg::CFG_FACE_MODE:  face_mode_reg  <= cfg_data[0];
                    default:                   face_mode_reg  <= face_mode_reg;
                endcase
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= s_tuser;
            cl_reg      <= s_tdata[11:0];
            cr_reg      <= s_tdata[24:12];
            w_reg       <= s_tdata[41:25];
            val_reg[0]  <= s_tdata[73:42];
            val_reg[1]  <= s_tdata[105:74];
            val_reg[2]  <= s_tdata[137:106];
            area_reg[0] <= s_tdata[169:138];
            area_reg[1] <= s_tdata[201:170];
            area_reg[2] <= s_tdata[233:202];
            vol_in_reg  <= s_tdata[264:234];
            step_reg    <= (s_tuser == fvdiv_pkg::OP_FACE && face_mode_reg) ? 4'd6 : 4'd0;
            acc_reg     <= 66'sd1 <<< (FB - 1);
        end
        case (state_reg)
            fvdiv_pkg::ST_RD_R:
            begin
                lvec_reg[0] <= vec_rd_data[31:0];
                lvec_reg[1] <= vec_rd_data[63:32];
                lvec_reg[2] <= vec_rd_data[95:64];
            end
            fvdiv_pkg::ST_CAP_R:
            begin
                rvec_reg[0] <= cr_reg[12] ? 32'sd0 : $signed(vec_rd_data[31:0]);
                rvec_reg[1] <= cr_reg[12] ? 32'sd0 : $signed(vec_rd_data[63:32]);
                rvec_reg[2] <= cr_reg[12] ? 32'sd0 : $signed(vec_rd_data[95:64]);
            end
            fvdiv_pkg::ST_MUL:
            begin
                prod_reg <= op_a * op_b;
            end
            fvdiv_pkg::ST_ACC:
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'd8)
                begin
                    flux_reg <= 50'(acc_sum >>> FB);
                    acc_reg  <= 66'sd1 <<< (FB - 1);
                end
                else if (step_reg < 4'd6 && step_reg[0])
                begin
                    q_reg[k_sel] <= 32'(acc_sum >>> FB);
                    acc_reg      <= 66'sd1 <<< (FB - 1);
                end
                else
                begin
                    acc_reg <= acc_sum;
                end
            end
            fvdiv_pkg::ST_DIV_PRE:
            begin
                neg_reg   <= flux_rd_data[63];
                dvol_reg  <= vol_rd_data;
                rem_reg   <= rd_mag[46:16];
                shift_reg <= {rd_mag[15:0], 16'b0};
                cnt_reg   <= 5'd0;
                quot_reg  <= 32'b0;
                if (rd_mag == 64'b0)
                begin
                    res_reg <= 32'b0;
                    sat_reg <= 1'b0;
                end
                else
                begin
                    res_reg <= flux_rd_data[63] ? fvdiv_pkg::NEG_LIMIT : fvdiv_pkg::POS_LIMIT;
                    sat_reg <= 1'b1;
                end
            end
            fvdiv_pkg::ST_DIV:
            begin
                shift_reg <= {shift_reg[30:0], 1'b0};
                cnt_reg   <= cnt_reg + 5'd1;
                if ({rem_reg, shift_reg[31]} >= {1'b0, dvol_reg})
                begin
                    rem_reg  <= trial[30:0];
                    quot_reg <= {quot_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= {rem_reg[29:0], shift_reg[31]};
                    quot_reg <= {quot_reg[30:0], 1'b0};
                end
            end
            fvdiv_pkg::ST_ROUND:
            begin
                res_reg <= neg_reg ? (32'b0 - q_clip) : q_clip;
                sat_reg <= q_over;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
        if (out_load)
        begin
            m_cell_reg <= cl_reg;
            m_div_reg  <= res_reg;
            m_sat_reg  <= sat_reg && (op_reg == fvdiv_pkg::OP_READ);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fvdiv_checker.sv =====
// ============================================================================
// fvdiv_checker
// Port-level checks of the divergence core, bound to its top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fvdiv_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [1:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [47:0]  m_tdata,
    input wire logic         m_tuser
);

    // A result that is not taken stays unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The block works on one transfer at a time.
    a_busy_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == fvdiv_pkg::OP_READ |=> !s_tready)
        else $error("ready high right after a read transfer");

    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == fvdiv_pkg::OP_LOAD |=> !s_tready)
        else $error("ready high right after a load transfer");

    // A clipped quotient sits exactly at one of the range limits.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
        m_tdata[43:12] == fvdiv_pkg::POS_LIMIT || m_tdata[43:12] == fvdiv_pkg::NEG_LIMIT)
        else $error("saturated result not at a limit");

endmodule

bind fv_vector_divergence_core fvdiv_checker u_fvdiv_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
